>>> design/tcc_pkg.sv
package tcc_pkg;

	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int CHAR_W = 8;
	localparam int CMD_W = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BELL   = 2'd3;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
	localparam logic [CHAR_W-1:0] CH_BEL = 8'd7;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

	localparam int TAB_STOP = 8;

	// register indexes (paddr[2])
	localparam logic REG_LINE_WRAP = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [CHAR_W-1:0] glyph;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic              last;
	} result_t;

	// results of one item, scroll (if any) ahead of the write
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} step_out_t;

endpackage

>>> design/tcc_cursor.sv
module tcc_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
	input  logic                        raw_mode,
	input  logic                        line_wrap,
	output tcc_pkg::step_out_t          step_out
);

	localparam logic [tcc_pkg::COL_W-1:0] COLS_V   = tcc_pkg::COL_W'(COLUMNS);
	localparam logic [tcc_pkg::COL_W-1:0] LAST_COL = tcc_pkg::COL_W'(COLUMNS - 1);
	localparam logic [tcc_pkg::ROW_W-1:0] LAST_ROW = tcc_pkg::ROW_W'(ROWS - 1);
	localparam logic [tcc_pkg::COL_W:0]   TAB_MASK = (tcc_pkg::COL_W + 1)'(tcc_pkg::TAB_STOP - 1);

	logic [tcc_pkg::COL_W-1:0] col_q, col_d;
	logic [tcc_pkg::ROW_W-1:0] row_q, row_d;

	logic                      is_glyph;
	logic                      pending;
	logic                      at_bottom;
	logic [tcc_pkg::COL_W-1:0] wcol;
	logic [tcc_pkg::ROW_W-1:0] wrow;
	logic                      wscroll;
	logic [tcc_pkg::COL_W:0]   col_inc;
	logic [tcc_pkg::COL_W:0]   tab_col;
	tcc_pkg::result_t          scroll_res, write_res, single_res;

	assign at_bottom = (row_q == LAST_ROW);
	assign pending = (col_q >= COLS_V);
	assign tab_col = ({1'b0, col_q} | TAB_MASK) + (tcc_pkg::COL_W + 1)'(1);

	always_comb begin
		case (char_code)
			tcc_pkg::CH_NUL, tcc_pkg::CH_BEL, tcc_pkg::CH_BS, tcc_pkg::CH_TAB,
			tcc_pkg::CH_LF, tcc_pkg::CH_FF, tcc_pkg::CH_CR: is_glyph = raw_mode;
			default: is_glyph = 1'b1;
		endcase
	end

	// glyph path: a pending wrap does a line feed (or, with wrap off, stays on the last column), then the write
	always_comb begin
		wcol = col_q;
		wrow = row_q;
		wscroll = 1'b0;
		if (pending) begin
			if (line_wrap) begin
				wcol = '0;
				if (at_bottom) begin
					wscroll = 1'b1;
				end else begin
					wrow = row_q + tcc_pkg::ROW_W'(1);
				end
			end else begin
				wcol = LAST_COL;
			end
		end
		col_inc = {1'b0, wcol} + (tcc_pkg::COL_W + 1)'(1);
	end

	always_comb begin
		scroll_res = '0;
		scroll_res.command = tcc_pkg::CMD_SCROLL;
		write_res = '0;
		write_res.command = tcc_pkg::CMD_WRITE;
		write_res.glyph = char_code;
		write_res.column = wcol;
		write_res.row = wrow;
		write_res.last = 1'b1;
		single_res = '0;
		single_res.last = 1'b1;

		col_d = col_q;
		row_d = row_q;
		step_out = '0;

		if (is_glyph) begin
			row_d = wrow;
			if (!line_wrap && col_inc >= {1'b0, COLS_V}) begin
				col_d = LAST_COL;
			end else begin
				col_d = col_inc[tcc_pkg::COL_W-1:0];
			end
			if (wscroll) begin
				step_out.count = 2'd2;
				step_out.res0 = scroll_res;
				step_out.res1 = write_res;
			end else begin
				step_out.count = 2'd1;
				step_out.res0 = write_res;
			end
		end else begin
			case (char_code)
				tcc_pkg::CH_BEL: begin
					single_res.command = tcc_pkg::CMD_BELL;
					step_out.count = 2'd1;
					step_out.res0 = single_res;
				end
				tcc_pkg::CH_BS: begin
					if (col_q != '0)
						col_d = col_q - tcc_pkg::COL_W'(1);
				end
				tcc_pkg::CH_TAB: begin
					if (tab_col > {1'b0, LAST_COL})
						col_d = LAST_COL;
					else
						col_d = tab_col[tcc_pkg::COL_W-1:0];
				end
				tcc_pkg::CH_LF: begin
					if (at_bottom) begin
						single_res.command = tcc_pkg::CMD_SCROLL;
						step_out.count = 2'd1;
						step_out.res0 = single_res;
					end else begin
						row_d = row_q + tcc_pkg::ROW_W'(1);
					end
				end
				tcc_pkg::CH_FF: begin
					single_res.command = tcc_pkg::CMD_CLEAR;
					step_out.count = 2'd1;
					step_out.res0 = single_res;
					col_d = '0;
					row_d = '0;
				end
				tcc_pkg::CH_CR: col_d = '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

>>> design/tcc_result_fifo.sv
module tcc_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  tcc_pkg::step_out_t push,
	input  logic               pop,
	output tcc_pkg::result_t   head,
	output logic               not_empty,
	output logic               room2
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	tcc_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_pop;

	assign not_empty = (cnt_q != '0);
	assign room2 = (cnt_q <= (PTR_W + 1)'(DEPTH - 2));
	assign head = mem_q[rptr_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wptr_q] <= push.res0;
		if (push.count == 2'd2)
			mem_q[wptr_q + PTR_W'(1)] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wptr_q <= wptr_q + PTR_W'(push.count);
			if (do_pop)
				rptr_q <= rptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(do_pop);
		end
	end

endmodule

>>> design/teletype_cursor_control_unit.sv
// An accepted item waits in the input register until the result queue has room for two results;
// it is then written to the queue, whose head drives m_tdata and m_tlast.
// Throughput: one item per cycle while each gives at most one result and the queue has room;
// the output side sends one result per cycle while m_tready is high, a wrap's scroll ahead of its write.
// Reset: arst_n clears cursor to row 0 column 0, empties the queue, sets line_wrap to 1.
module teletype_cursor_control_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] raw_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] command, [9:2] glyph, [16:10] column,
	                               // [21:17] row, [23:22] zero
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                        valid_s1;
	logic [tcc_pkg::CHAR_W-1:0]  char_s1;
	logic                        raw_s1;
	logic                        line_wrap_q;
	logic                        room2;
	logic                        advance;
	tcc_pkg::step_out_t          step_out, push;
	tcc_pkg::result_t            head;

	assign pready = 1'b1;
	assign prdata = {31'b0, line_wrap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_wrap_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == tcc_pkg::REG_LINE_WRAP) begin
			line_wrap_q <= pwdata[0];
		end
	end

	// item leaves the input register once the queue has space for two results
	assign advance = valid_s1 && room2;
	assign s_tready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			raw_s1 <= s_tuser[0];
		end
	end

	tcc_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_cursor (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.char_code(char_s1),
		.raw_mode(raw_s1),
		.line_wrap(line_wrap_q),
		.step_out(step_out)
	);

	always_comb begin
		push = step_out;
		if (!advance)
			push.count = 2'd0;
	end

	tcc_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(m_tready),
		.head(head),
		.not_empty(m_tvalid),
		.room2(room2)
	);

	assign m_tdata = {2'b00, head.row, head.column, head.glyph, head.command};
	assign m_tlast = head.last;

endmodule

>>> design/tcc_checker.sv
module tcc_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 24
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// only a write carries glyph and position
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != tcc_pkg::CMD_WRITE |-> m_tdata[23:2] == 22'd0)
		else $error("non-write command with nonzero fields");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:10] < 7'(COLUMNS) && m_tdata[21:17] < 5'(ROWS))
		else $error("write position off screen");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tcc_pkg::CMD_BELL || m_tdata[1:0] == tcc_pkg::CMD_CLEAR)
		|-> m_tlast)
		else $error("bell or clear not marked last");

endmodule

bind teletype_cursor_control_unit tcc_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
